// ----- src/gdse_pkg.sv -----
// Shared constants, record types and tables for the Gregorian date shift engine.
package gdse_pkg;

    // Pipeline depths of the two converters and of the whole engine
    localparam int JDN_LAT  = 2;
    localparam int DATE_LAT = 7;
    localparam int LAT      = 2 * JDN_LAT + 2 * DATE_LAT + 3;

    // Substitute date for requests that fail the round trip, and its day number
    localparam logic [13:0] DFLT_YEAR  = 14'd1959;
    localparam logic [3:0]  DFLT_MONTH = 4'd5;
    localparam logic [4:0]  DFLT_DAY   = 5'd11;
    localparam logic [23:0] DFLT_JD    = 24'd2436700;

    localparam logic [16:0] YEAR_MIN = 17'sd1;
    localparam logic [16:0] YEAR_MAX = 17'sd9999;

    localparam logic [24:0] JDN_BIAS = 25'd32075;
    localparam logic [24:0] JD_OFS   = 25'd68569;

    // Reciprocals ceil(2^k / C); k chosen so that x * C < 2^k over the operand range,
    // which makes (x * M) >> k the exact floor quotient.
    localparam longint unsigned M_100 = ((64'd1 << 22) + 64'd99) / 64'd100;
    localparam longint unsigned M_N   = ((64'd1 << 45) + 64'd146096) / 64'd146097;
    localparam longint unsigned M_I   = ((64'd1 << 49) + 64'd1461000) / 64'd1461001;
    localparam longint unsigned M_J   = ((64'd1 << 28) + 64'd2446) / 64'd2447;
    localparam longint unsigned MJ80  = 64'd80 * M_J;
    localparam longint unsigned M_80  = ((64'd1 << 24) + 64'd79) / 64'd80;
    localparam longint unsigned K80   = 64'd2447 * M_80;
    localparam longint unsigned M_7   = ((64'd1 << 27) + 64'd6) / 64'd7;

    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [20:0] offset;
    } t_side_a;

    typedef struct packed {
        t_side_a     a;
        logic [23:0] jd;
    } t_side_b;

    typedef struct packed {
        logic        valid;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [23:0] jsel;
        logic [23:0] jsh;
    } t_side_c;

    typedef struct packed {
        logic        valid;
        logic        oor;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [23:0] jfin;
    } t_side_d;

    // floor(367 * (m - 2 - 12a) / 12), a = -1 for months up to February
    function automatic logic [8:0] f_month_term(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0:  v = 9'd305;
            4'd1:  v = 9'd336;
            4'd2:  v = 9'd367;
            4'd3:  v = 9'd30;
            4'd4:  v = 9'd61;
            4'd5:  v = 9'd91;
            4'd6:  v = 9'd122;
            4'd7:  v = 9'd152;
            4'd8:  v = 9'd183;
            4'd9:  v = 9'd214;
            4'd10: v = 9'd244;
            4'd11: v = 9'd275;
            4'd12: v = 9'd305;
            4'd13: v = 9'd336;
            4'd14: v = 9'd367;
            4'd15: v = 9'd397;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/gdse_in_if.sv -----
// Request channel: date and day offset with valid/ready handshake.
interface gdse_in_if;
    logic               valid;
    logic               ready;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic signed [20:0] offset_days;

    modport source(output valid, year_in, month_in, day_in, offset_days, input ready);
    modport sink(input valid, year_in, month_in, day_in, offset_days, output ready);
endinterface

// ----- src/gdse_out_if.sv -----
// Result channel: shifted date, flags, weekday and day of year with valid/ready handshake.
interface gdse_out_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic        out_of_range;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [8:0]  year_day;

    modport source(output valid, date_valid, out_of_range, year_out, month_out, day_out,
                   weekday, year_day, input ready);
    modport sink(input valid, date_valid, out_of_range, year_out, month_out, day_out,
                 weekday, year_day, output ready);
endinterface

// ----- src/gdse_pipe_dly.sv -----
// Enabled shift line that carries side data alongside a converter.
module gdse_pipe_dly #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[D-1];
endmodule

// ----- src/gdse_jdn.sv -----
// Two-stage date to Julian Day Number converter.
module gdse_jdn (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    output logic [23:0] o_jd
);
    import gdse_pkg::*;

    logic        lo_m;
    logic [14:0] t;
    logic [14:0] u;
    logic [24:0] r_p1;
    logic [30:0] r_qu;
    logic [9:0]  r_c;
    logic [8:0]  q100;
    logic [9:0]  sub;
    logic [23:0] r_jd;

    always_comb begin
        lo_m = (i_month <= 4'd2);
        t    = 15'(i_year) + (lo_m ? 15'd4799 : 15'd4800);
        u    = 15'(i_year) + (lo_m ? 15'd4899 : 15'd4900);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= 25'(t) * 25'd1461;
            r_qu <= 31'(u) * 31'(M_100);
            r_c  <= 10'(f_month_term(i_month)) + 10'(i_day);
        end
    end

    always_comb begin
        q100 = r_qu[30:22];
        sub  = 10'((11'(q100) * 11'd3) >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // always positive over the whole input range
            r_jd <= 24'(25'(r_p1[24:2]) + 25'(r_c) - 25'(sub) - JDN_BIAS);
        end
    end

    assign o_jd = r_jd;
endmodule

// ----- src/gdse_jd2date.sv -----
// Seven-stage Julian Day Number to date converter.
module gdse_jd2date (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [23:0]        i_jd,
    output logic signed [16:0] o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day
);
    import gdse_pkg::*;

    logic [24:0] l0;
    logic [24:0] r_l0, r_l0b;
    logic [54:0] r_pn;
    logic [9:0]  n;
    logic [27:0] r_pn2;
    logic [9:0]  r_n2, r_n3, r_n4, r_n5, r_n6;
    logic [24:0] l1w;
    logic [15:0] l1;
    logic [15:0] r_l1, r_l1b;
    logic [27:0] r_pi;
    logic [56:0] r_qi;
    logic [7:0]  i;
    logic [15:0] l2w;
    logic [8:0]  r_l2, r_l2b;
    logic [7:0]  r_i5, r_i6;
    logic [32:0] r_qj;
    logic [4:0]  j;
    logic [33:0] pk;
    logic [9:0]  kd;
    logic        l3;
    logic [4:0]  mw;
    logic [16:0] yw;
    logic signed [16:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    assign l0 = 25'(i_jd) + JD_OFS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l0 <= l0;
            r_pn <= 55'({l0, 2'b00}) * 55'(M_N);
        end
    end

    assign n = r_pn[54:45];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l0b <= r_l0;
            r_n2  <= n;
            r_pn2 <= 28'(n) * 28'd146097;
        end
    end

    always_comb begin
        l1w = r_l0b - 25'((29'(r_pn2) + 29'd3) >> 2);
        l1  = l1w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1 <= l1;
            r_n3 <= r_n2;
            r_pi <= (28'(l1) + 28'd1) * 28'd4000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1b <= r_l1;
            r_n4  <= r_n3;
            r_qi  <= 57'(r_pi) * 57'(M_I);
        end
    end

    always_comb begin
        i   = r_qi[56:49];
        l2w = r_l1b - 16'((19'(i) * 19'd1461) >> 2) + 16'd31;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l2 <= l2w[8:0];
            r_i5 <= i;
            r_n5 <= r_n4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qj  <= 33'(r_l2) * 33'(MJ80);
            r_l2b <= r_l2;
            r_i6  <= r_i5;
            r_n6  <= r_n5;
        end
    end

    always_comb begin
        j  = r_qj[32:28];
        pk = (34'(j) * 34'(K80)) >> 24;
        kd = 10'(r_l2b) - pk[9:0];
        l3 = (j >= 5'd11);
        mw = j + 5'd2 - (l3 ? 5'd12 : 5'd0);
        yw = 17'(r_n6) * 17'd100 - 17'd4900 + 17'(r_i6) + 17'(l3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_year  <= $signed(yw);
            r_month <= mw[3:0];
            r_day   <= kd[4:0];
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
endmodule

// ----- src/gregorian_date_shift_engine.sv -----
// Top level of the Gregorian date shift engine.
// Takes one request per cycle while the result side does not stall, and returns one
// result per request, in order. The request is converted to a Julian Day Number and
// back to check it (a failing date is replaced by 1959-05-11), the offset is added and
// the sum is converted back (a result year outside 1 to 9999 keeps the checked date,
// flagged out of range); weekday and day of year come from the final day number. The
// 21 stages are two day-number converters (2 stages each), two date converters (7
// stages each, set by the chain of reciprocal multiplies), the check and range-select
// registers and the output register. A stall on the result side holds the whole
// pipeline; no state survives between requests and reset only clears the valid bits.
module gregorian_date_shift_engine (
    input logic       i_clk,
    input logic       i_rst_n,
    gdse_in_if.sink   i_req,
    gdse_out_if.source o_res
);
    import gdse_pkg::*;

    logic           en;
    logic [LAT-1:0] r_vld;

    t_side_a w_sa_in, w_sa;
    t_side_b w_sb_in, w_sb;
    t_side_c r_sc, w_scd;
    t_side_d r_sd, w_sdd;

    logic [23:0]        w_jd_a;
    logic signed [16:0] w_ry, w_sy;
    logic [3:0]         w_rm, w_sm;
    logic [4:0]         w_rd, w_sd;
    logic               n_ok;
    logic [23:0]        n_jsel;
    logic               n_oor;
    logic [23:0]        w_jan1;
    logic [48:0]        r_pq;
    logic [23:0]        r_jf;
    logic [23:0]        n_wd_full;
    logic [2:0]         r_wd;
    logic [23:0]        n_yd_full;

    logic        r_o_valid_date;
    logic        r_o_oor;
    logic [13:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [2:0]  r_o_wd;
    logic [8:0]  r_o_yd;

    assign en          = !r_vld[LAT-1] || o_res.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // Day number of the request as given
    always_comb begin
        w_sa_in.year   = i_req.year_in;
        w_sa_in.month  = i_req.month_in;
        w_sa_in.day    = i_req.day_in;
        w_sa_in.offset = i_req.offset_days;
    end

    gdse_jdn u_jdn_in (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_year  (i_req.year_in),
        .i_month (i_req.month_in),
        .i_day   (i_req.day_in),
        .o_jd    (w_jd_a)
    );

    gdse_pipe_dly #(.W($bits(t_side_a)), .D(JDN_LAT)) u_dly_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_sa_in),
        .o_q   (w_sa)
    );

    // Round trip back to a date
    always_comb begin
        w_sb_in.a  = w_sa;
        w_sb_in.jd = w_jd_a;
    end

    gdse_jd2date u_chk (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_jd    (w_jd_a),
        .o_year  (w_ry),
        .o_month (w_rm),
        .o_day   (w_rd)
    );

    gdse_pipe_dly #(.W($bits(t_side_b)), .D(DATE_LAT)) u_dly_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_sb_in),
        .o_q   (w_sb)
    );

    always_comb begin
        n_ok   = (w_ry == $signed({3'b000, w_sb.a.year})) && (w_rm == w_sb.a.month)
                 && (w_rd == w_sb.a.day);
        n_jsel = n_ok ? w_sb.jd : DFLT_JD;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc.valid <= n_ok;
            r_sc.year  <= n_ok ? w_sb.a.year : DFLT_YEAR;
            r_sc.month <= n_ok ? w_sb.a.month : DFLT_MONTH;
            r_sc.day   <= n_ok ? w_sb.a.day : DFLT_DAY;
            r_sc.jsel  <= n_jsel;
            // sum stays positive for every offset
            r_sc.jsh   <= 24'(25'(n_jsel) + {{4{w_sb.a.offset[20]}}, w_sb.a.offset});
        end
    end

    // Shifted day number back to a date
    gdse_jd2date u_shift (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_jd    (r_sc.jsh),
        .o_year  (w_sy),
        .o_month (w_sm),
        .o_day   (w_sd)
    );

    gdse_pipe_dly #(.W($bits(t_side_c)), .D(DATE_LAT)) u_dly_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_sc),
        .o_q   (w_scd)
    );

    assign n_oor = (w_sy < $signed(YEAR_MIN)) || (w_sy > $signed(YEAR_MAX));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd.valid <= w_scd.valid;
            r_sd.oor   <= n_oor;
            r_sd.year  <= n_oor ? w_scd.year : w_sy[13:0];
            r_sd.month <= n_oor ? w_scd.month : w_sm;
            r_sd.day   <= n_oor ? w_scd.day : w_sd;
            r_sd.jfin  <= n_oor ? w_scd.jsel : w_scd.jsh;
        end
    end

    // New Year's day number of the result year, and weekday in parallel
    gdse_jdn u_jan1 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_year  (r_sd.year),
        .i_month (4'd1),
        .i_day   (5'd1),
        .o_jd    (w_jan1)
    );

    gdse_pipe_dly #(.W($bits(t_side_d)), .D(JDN_LAT)) u_dly_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_sd),
        .o_q   (w_sdd)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pq <= 49'(r_sd.jfin) * 49'(M_7);
            r_jf <= r_sd.jfin;
        end
    end

    assign n_wd_full = r_jf - 24'(r_pq[48:27]) * 24'd7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wd <= n_wd_full[2:0];
        end
    end

    assign n_yd_full = w_sdd.jfin - w_jan1 + 24'd1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_valid_date <= w_sdd.valid;
            r_o_oor        <= w_sdd.oor;
            r_o_year       <= w_sdd.year;
            r_o_month      <= w_sdd.month;
            r_o_day        <= w_sdd.day;
            r_o_wd         <= r_wd;
            r_o_yd         <= n_yd_full[8:0];
        end
    end

    assign o_res.valid        = r_vld[LAT-1];
    assign o_res.date_valid   = r_o_valid_date;
    assign o_res.out_of_range = r_o_oor;
    assign o_res.year_out     = r_o_year;
    assign o_res.month_out    = r_o_month;
    assign o_res.day_out      = r_o_day;
    assign o_res.weekday      = r_o_wd;
    assign o_res.year_day     = r_o_yd;
endmodule
